### rtl/escape_byte_stuffing_codec_macros.svh
// Assertion macros used by the checker file.
`ifndef ESCAPE_BYTE_STUFFING_CODEC_MACROS_SVH
`define ESCAPE_BYTE_STUFFING_CODEC_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ESCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ESCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/escb_pkg.sv
`default_nettype none

package escb_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int OUT_COUNT_W    = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = 1;
   localparam int QUEUE_CNT_W    = 2;

   localparam logic       DIRECTION_RESET = 1'b1;
   localparam logic [7:0] FLAG_RESET      = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET    = 8'h7D;
   localparam logic [7:0] CODE_ESC        = 8'h01;
   localparam logic [7:0] CODE_FLAG       = 8'h02;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIRECTION   = 2'd0,
      CSR_FLAG_BYTE   = 2'd1,
      CSR_ESCAPE_BYTE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       direction;
      logic [7:0] flag_byte;
      logic [7:0] escape_byte;
   } cfg_type;

   // One classified request: one or two bytes, or an error result.
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       pair;
      logic       last;
      logic       err;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

### rtl/escb_req_if.sv
`default_nettype none

interface escb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       in_last;

   modport source (output valid, output data_byte, output in_last, input ready);
   modport sink (input valid, input data_byte, input in_last, output ready);
endinterface

`default_nettype wire

### rtl/escb_rsp_if.sv
`default_nettype none

interface escb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_last;
   logic        error;
   logic [15:0] out_count;

   modport source (output valid, output out_byte, output out_last, output error,
                   output out_count, input ready);
   modport sink (input valid, input out_byte, input out_last, input error,
                 input out_count, output ready);
endinterface

`default_nettype wire

### rtl/escb_csr_if.sv
`default_nettype none

interface escb_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/escb_front.sv
`default_nettype none

module escb_front (
   input  wire                    clock,
   input  wire                    reset,
   input  escb_pkg::cfg_type      cfg,
   escb_req_if.sink               req_ch,
   input  escb_pkg::q_status_type q_status,
   output logic                   push,
   output escb_pkg::cmd_type      cmd
);

   logic pending_ff, pending_in;
   logic dropping_ff, dropping_in;
   logic accept;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      pending_in      = pending_ff;
      dropping_in     = dropping_ff;
      push            = 1'b0;
      cmd.first_byte  = req_ch.data_byte;
      cmd.second_byte = escb_pkg::CODE_ESC;
      cmd.pair        = 1'b0;
      cmd.last        = req_ch.in_last;
      cmd.err         = 1'b0;
      if (accept) begin
         if (dropping_ff) begin
            if (req_ch.in_last) begin
               dropping_in = 1'b0;
            end
         end else if (cfg.direction) begin
            pending_in = 1'b0;
            push       = 1'b1;
            if (req_ch.data_byte == cfg.flag_byte) begin
               cmd.first_byte  = cfg.escape_byte;
               cmd.second_byte = escb_pkg::CODE_FLAG;
               cmd.pair        = 1'b1;
            end else if (req_ch.data_byte == cfg.escape_byte) begin
               cmd.first_byte  = cfg.escape_byte;
               cmd.second_byte = escb_pkg::CODE_ESC;
               cmd.pair        = 1'b1;
            end
         end else if (pending_ff) begin
            pending_in = 1'b0;
            push       = 1'b1;
            if (req_ch.data_byte == escb_pkg::CODE_ESC) begin
               cmd.first_byte = cfg.escape_byte;
            end else if (req_ch.data_byte == escb_pkg::CODE_FLAG) begin
               cmd.first_byte = cfg.flag_byte;
            end else begin
               cmd.err     = 1'b1;
               cmd.last    = 1'b1;
               dropping_in = !req_ch.in_last;
            end
         end else if (req_ch.data_byte == cfg.escape_byte) begin
            if (req_ch.in_last) begin
               push     = 1'b1;
               cmd.err  = 1'b1;
            end else begin
               pending_in = 1'b1;
            end
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         dropping_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         dropping_ff <= dropping_in;
      end
   end

endmodule

`default_nettype wire

### rtl/escb_queue.sv
`default_nettype none

module escb_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  escb_pkg::cmd_type       push_cmd,
   input  wire                     pop,
   output escb_pkg::cmd_type       head_cmd,
   output escb_pkg::q_status_type  status
);

   escb_pkg::cmd_type entry_ff [escb_pkg::QUEUE_DEPTH];
   logic [escb_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [escb_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [escb_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == escb_pkg::QUEUE_CNT_W'(escb_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/escb_back.sv
`default_nettype none

module escb_back #(
   parameter int COUNT_WIDTH = escb_pkg::COUNT_WIDTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  escb_pkg::cmd_type      head_cmd,
   input  escb_pkg::q_status_type q_status,
   output logic                   pop,
   escb_rsp_if.source             rsp_ch
);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;
   logic                   error_ff, error_in;
   logic [escb_pkg::OUT_COUNT_W-1:0] out_count_ff, out_count_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic                   load;
   logic                   res_last;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = out_byte_ff;
   assign rsp_ch.out_last  = out_last_ff;
   assign rsp_ch.error     = error_ff;
   assign rsp_ch.out_count = out_count_ff;

   assign load    = !rsp_valid_ff || rsp_ch.ready;
   assign cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      error_in     = error_ff;
      out_count_in = out_count_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      res_last     = 1'b0;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (head_cmd.err) begin
               out_byte_in  = '0;
               out_last_in  = 1'b1;
               error_in     = 1'b1;
               out_count_in = escb_pkg::OUT_COUNT_W'(cnt_ff);
               cnt_in       = '0;
               pop          = 1'b1;
            end else begin
               if (!phase_ff) begin
                  out_byte_in = head_cmd.first_byte;
                  res_last    = head_cmd.last && !head_cmd.pair;
                  phase_in    = head_cmd.pair;
                  pop         = !head_cmd.pair;
               end else begin
                  out_byte_in = head_cmd.second_byte;
                  res_last    = head_cmd.last;
                  phase_in    = 1'b0;
                  pop         = 1'b1;
               end
               out_last_in  = res_last;
               error_in     = 1'b0;
               out_count_in = res_last ? escb_pkg::OUT_COUNT_W'(cnt_inc) : '0;
               cnt_in       = res_last ? '0 : cnt_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      error_ff     <= error_in;
      out_count_ff <= out_count_in;
   end

endmodule

`default_nettype wire

### rtl/escape_byte_stuffing_codec.sv
// The front takes one request per cycle while the two-entry command queue is not full;
// a byte that escapes into a pair holds the response register for both of its bytes,
// so the queue can fill and stall the requests.
// Reset (synchronous, active high) clears the queue, response register, message state
// and restores direction = escape, flag byte 0x7E, escape byte 0x7D.
`default_nettype none

module escape_byte_stuffing_codec #(
   parameter int COUNT_WIDTH = escb_pkg::COUNT_WIDTH
) (
   input  wire        clock,
   input  wire        reset,
   escb_req_if.sink   req_ch,
   escb_rsp_if.source rsp_ch,
   escb_csr_if.sink   csr_ch
);

   escb_pkg::cfg_type      cfg_ff, cfg_in;
   escb_pkg::cmd_type      push_cmd;
   escb_pkg::cmd_type      head_cmd;
   escb_pkg::q_status_type q_status;
   logic                   push;
   logic                   pop;

   // Take configuration writes at any time; each lands at its own edge, so the
   // sender keeps them to periods with nothing in flight.
   assign csr_ch.ready = 1'b1;

   // Decode the register index; drop writes to unused indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            escb_pkg::CSR_DIRECTION:   cfg_in.direction   = csr_ch.wdata[0];
            escb_pkg::CSR_FLAG_BYTE:   cfg_in.flag_byte   = csr_ch.wdata;
            escb_pkg::CSR_ESCAPE_BYTE: cfg_in.escape_byte = csr_ch.wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction   <= escb_pkg::DIRECTION_RESET;
         cfg_ff.flag_byte   <= escb_pkg::FLAG_RESET;
         cfg_ff.escape_byte <= escb_pkg::ESCAPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept each request, track pending escape and dropping, classify
   // into a command (single byte, escape pair, or error).
   escb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .cmd      (push_cmd)
   );

   // Decouple front and back so each side can stall on its own.
   escb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Back: expand commands into responses, count emitted bytes, hold the
   // response register while the sink stalls.
   escb_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

### rtl/escb_checker.sv
`default_nettype none
`include "escape_byte_stuffing_codec_macros.svh"

module escb_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [7:0]  out_byte,
   input wire        out_last,
   input wire        error,
   input wire [15:0] out_count
);

   `ESCB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(out_byte) && $stable(out_last) && $stable(error)
      && $stable(out_count), "stalled response changed")
   `ESCB_ASSERT_NOW(a_err_form, clock, reset, rsp_valid && error,
      out_last && (out_byte == 8'd0), "error response not last or nonzero byte")
   `ESCB_ASSERT_NOW(a_count_last, clock, reset, rsp_valid && !out_last,
      out_count == 16'd0, "count on a non-final response")
   `ESCB_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid,
      "response valid after reset")

endmodule

bind escape_byte_stuffing_codec escb_checker u_escb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_byte  (rsp_ch.out_byte),
   .out_last  (rsp_ch.out_last),
   .error     (rsp_ch.error),
   .out_count (rsp_ch.out_count)
);

`default_nettype wire
